// ===== hdl/booth_radix2_signed_multiplier_assert.svh =====
// assertion macros used by the booth multiplier checker
`ifndef BOOTH_RADIX2_SIGNED_MULTIPLIER_ASSERT_SVH
`define BOOTH_RADIX2_SIGNED_MULTIPLIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BR2_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BR2_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/br2_pkg.sv =====
// shared types, constants and the booth round function
`timescale 1ns / 1ps

package br2_pkg;

    // operand width and derived widths
    localparam int WIDTH      = 8;
    localparam int PROD_W     = 2 * WIDTH - 1;
    localparam int NUM_STAGES = WIDTH;

    // most negative operand, rejected at the input
    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    // largest product magnitude for valid operands
    localparam longint MAX_MAG  = (longint'(1) <<< (WIDTH - 1)) - 1;
    localparam longint PROD_MAX = MAX_MAG * MAX_MAG;

    // booth recoding of {current bit, previous bit}
    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    // working word of one item between rounds
    typedef struct packed {
        logic [WIDTH-1:0] ac;
        logic [WIDTH-1:0] q;
        logic             qprev;
        logic [WIDTH-1:0] mcand;
        logic             invalid;
    } booth_word_t;

    // valid bit travelling with the working word
    typedef struct packed {
        logic        valid;
        booth_word_t data;
    } stage_bus_t;

    // one booth round: add or subtract, then arithmetic shift of {ac, q}
    function automatic booth_word_t booth_round(input booth_word_t w);
        booth_word_t      r;
        logic [WIDTH-1:0] acc;
        r = w;
        case ({w.q[0], w.qprev})
            BOOTH_SUB: acc = w.ac - w.mcand;
            BOOTH_ADD: acc = w.ac + w.mcand;
            default:   acc = w.ac;
        endcase
        r.ac    = {acc[WIDTH-1], acc[WIDTH-1:1]};
        r.q     = {acc[0], w.q[WIDTH-1:1]};
        r.qprev = w.q[0];
        return r;
    endfunction

endpackage

// ===== hdl/br2_stage.sv =====
// one pipeline stage doing a single booth round
`timescale 1ns / 1ps

module br2_stage
    import br2_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_bus_t up,
    output logic       up_ready,
    output stage_bus_t down,
    input  logic       down_ready
);

    logic        valid_reg;
    booth_word_t data_reg;
    booth_word_t data_next;

    // stage can take a new word when empty or when its word moves on
    assign up_ready  = !valid_reg || down_ready;
    assign data_next = booth_round(up.data);

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up.valid;
        end
    end

    // working word, no reset
    always_ff @(posedge clk)
    begin
        if (up_ready && up.valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down.valid = valid_reg;
    assign down.data  = data_reg;

endmodule

// ===== hdl/booth_radix2_signed_multiplier.sv =====
// top level of the pipelined radix-2 booth signed multiplier
`timescale 1ns / 1ps

// usage:
// input channel: multiplicand and multiplier with in_valid; a transaction is
//   taken at a rising edge with in_valid high and in_stall low
// output channel: product and invalid with out_valid; a transaction is taken
//   at a rising edge with out_valid high and out_stall low
// one booth round per pipeline stage, WIDTH stages plus an output register
// a transaction passes through the WIDTH round stages, then the output register, before out_valid
// throughput: one transaction per cycle while out_stall stays low
// an operand equal to the most negative value sets invalid and gives product 0
// reset clears every valid bit, so the pipeline comes up empty
// when the receiver stalls, the output holds and each stage fills its bubble;
//   in_stall rises only once every stage and the output register are full
// no state is kept between transactions

module booth_radix2_signed_multiplier
    import br2_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [WIDTH-1:0]  multiplicand,
    input  logic signed [WIDTH-1:0]  multiplier,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [PROD_W-1:0] product,
    output logic                     invalid
);

    stage_bus_t bus [0:NUM_STAGES];
    logic       ready [0:NUM_STAGES];

    logic              out_valid_reg;
    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;
    logic              invalid_reg;

    // initial booth word built from the input operands
    always_comb
    begin
        bus[0].valid        = in_valid;
        bus[0].data.ac      = '0;
        bus[0].data.q       = $unsigned(multiplier);
        bus[0].data.qprev   = 1'b0;
        bus[0].data.mcand   = $unsigned(multiplicand);
        bus[0].data.invalid = ($unsigned(multiplicand) == MOST_NEG) ||
                              ($unsigned(multiplier) == MOST_NEG);
    end

    assign in_stall = !ready[0];

    // chain of round stages
    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        br2_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .up         (bus[s]),
            .up_ready   (ready[s]),
            .down       (bus[s+1]),
            .down_ready (ready[s+1])
        );
    end

    // output register acts as the last stage
    assign ready[NUM_STAGES] = !out_valid_reg || !out_stall;

    assign product_next = bus[NUM_STAGES].data.invalid ? '0 :
                          {bus[NUM_STAGES].data.ac[WIDTH-2:0], bus[NUM_STAGES].data.q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ready[NUM_STAGES])
        begin
            out_valid_reg <= bus[NUM_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[NUM_STAGES] && bus[NUM_STAGES].valid)
        begin
            product_reg <= product_next;
            invalid_reg <= bus[NUM_STAGES].data.invalid;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = $signed(product_reg);
    assign invalid   = invalid_reg;

endmodule

// ===== hdl/br2_checker.sv =====
// port-level checker for the booth multiplier and its bind
`timescale 1ns / 1ps
`include "booth_radix2_signed_multiplier_assert.svh"

module br2_checker
    import br2_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [PROD_W-1:0] product,
    input logic                     invalid
);

    // rejected operands always give a zero product
    `BR2_ASSERT_NOW(a_invalid_zero, out_valid && invalid, product == '0,
                    "invalid with nonzero product")

    // valid operands never give a product beyond the largest magnitude
    `BR2_ASSERT_NOW(a_prod_range, out_valid && !invalid,
                    (product <= PROD_MAX) && (product >= -PROD_MAX), "product out of range")

    // back-pressure reaches the input only with a full pipe behind a stalled output
    `BR2_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
                    "input stalled without output stall")

    // a stalled result holds
    `BR2_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(product) && $stable(invalid), "stalled result changed")

endmodule

bind booth_radix2_signed_multiplier br2_checker u_br2_checker (.*);
